// ===== design/ritoa_pkg.sv =====
// ----------------------------------------------------------------------------
// ritoa_pkg
// Shared types, constants and the digit-to-character map of the radix
// integer-to-ASCII converter.
// ----------------------------------------------------------------------------
package ritoa_pkg;

  localparam int unsigned ValueWidthDef = 64;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [5:0] RadixMin = 6'd2;
  localparam logic [5:0] RadixMax = 6'd36;
  localparam logic [5:0] RadixDec = 6'd10;

  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharNine  = 7'h39;
  localparam logic [6:0] CharLowA  = 7'h61;
  localparam logic [6:0] CharLowZ  = 7'h7A;

  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  radix;
    logic        signed_mode;
  } in_item_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
    logic       empty_res;
  } out_item_t;

  typedef struct packed {
    logic       bad_radix;
    logic       neg_dec;
    logic [5:0] radix;
  } job_ctrl_t;

  function automatic logic [6:0] digit_to_char(input logic [5:0] digit);
    logic [6:0] ch;
    if (digit < 6'd10) begin
      ch = CharZero + {1'b0, digit};
    end else begin
      ch = CharLowA + {1'b0, digit} - 7'd10;
    end
    return ch;
  endfunction

endpackage

// ===== design/ritoa_front.sv =====
// ----------------------------------------------------------------------------
// ritoa_front
// Classifies an incoming item: radix check, sign handling and magnitude
// extraction for the conversion engine.
// ----------------------------------------------------------------------------
module ritoa_front
  import ritoa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  in_item_t               item_i,
  output job_ctrl_t              job_ctrl_o,
  output logic [VALUE_WIDTH-1:0] job_mag_o
);

  logic [31:0] low;
  logic        neg;
  logic [31:0] mag32;

  always_comb begin
    low   = item_i.value[31:0];
    neg   = item_i.signed_mode & low[31];
    mag32 = neg ? (32'd0 - low) : low;

    job_ctrl_o.bad_radix = (item_i.radix < RadixMin) || (item_i.radix > RadixMax);
    job_ctrl_o.neg_dec   = neg && (item_i.radix == RadixDec);
    job_ctrl_o.radix     = item_i.radix;

    job_mag_o = item_i.signed_mode ? VALUE_WIDTH'(mag32) : item_i.value[VALUE_WIDTH-1:0];
  end

endmodule

// ===== design/ritoa_fifo.sv =====
// ----------------------------------------------------------------------------
// ritoa_fifo
// Short job queue between the classifier and the conversion engine.
// ----------------------------------------------------------------------------
module ritoa_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  input  logic              pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/ritoa_back.sv =====
// ----------------------------------------------------------------------------
// ritoa_back
// Conversion engine: shared restoring divider producing one remainder digit
// per pass, digit stack, and character emission through an output register.
// ----------------------------------------------------------------------------
module ritoa_back
  import ritoa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  job_ctrl_t              job_ctrl_i,
  input  logic [VALUE_WIDTH-1:0] job_mag_i,
  output logic                   job_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o
);

  localparam int unsigned DivBits  = 4;
  localparam int unsigned DivW     = ((VALUE_WIDTH + DivBits - 1) / DivBits) * DivBits;
  localparam int unsigned NumSteps = DivW / DivBits;
  localparam int unsigned StepW    = $clog2(NumSteps);
  localparam int unsigned AddrW    = $clog2(VALUE_WIDTH);
  localparam int unsigned CntW     = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StRead,
    StChar,
    StPut
  } state_e;

  state_e            state_q;
  state_e            ret_q;
  logic [DivW-1:0]   mag_q;
  logic [DivW-1:0]   mag_d;
  logic [5:0]        radix_q;
  logic              neg_dec_q;
  logic [StepW-1:0]  step_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   cnt_dec;
  logic [5:0]        rem_q;
  logic [5:0]        rem_d;
  logic [5:0]        rd_q;
  out_item_t         pend_q;
  out_item_t         out_q;
  logic              out_valid_q;
  logic [DivBits-1:0] quot;
  logic              step_last;
  logic              quot_zero;
  logic              cnt_full;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;

  logic [5:0] stack_mem [VALUE_WIDTH];

  always_comb begin
    logic [6:0] trial;
    rem_d = rem_q;
    quot  = '0;
    for (int k = 0; k < DivBits; k++) begin
      trial = {rem_d, mag_q[DivW-1-k]};
      if (trial >= {1'b0, radix_q}) begin
        trial               = trial - {1'b0, radix_q};
        quot[DivBits-1-k]   = 1'b1;
      end
      rem_d = trial[5:0];
    end
    mag_d = {mag_q[DivW-DivBits-1:0], quot};
  end

  assign step_last = (step_q == StepW'(NumSteps - 1));
  assign quot_zero = (mag_d == '0);
  assign cnt_full  = (cnt_q == CntW'(VALUE_WIDTH - 1));
  assign cnt_dec   = cnt_q - 1'b1;
  assign wr_addr   = cnt_q[AddrW-1:0];
  assign rd_addr   = cnt_dec[AddrW-1:0];

  assign job_pop_o   = (state_q == StIdle) && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StDiv && step_last) begin
      stack_mem[wr_addr] <= rem_d;
    end
    if (state_q == StRead) begin
      rd_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != StPut) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            radix_q   <= job_ctrl_i.radix;
            neg_dec_q <= job_ctrl_i.neg_dec;
            mag_q     <= DivW'(job_mag_i);
            rem_q     <= '0;
            step_q    <= '0;
            cnt_q     <= '0;
            if (job_ctrl_i.bad_radix) begin
              pend_q.digit_char <= '0;
              pend_q.last       <= 1'b1;
              pend_q.empty_res  <= 1'b1;
              ret_q             <= StIdle;
              state_q           <= StPut;
            end else begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          mag_q <= mag_d;
          if (step_last) begin
            rem_q  <= '0;
            step_q <= '0;
            cnt_q  <= cnt_q + 1'b1;
            if (quot_zero || cnt_full) begin
              if (neg_dec_q) begin
                pend_q.digit_char <= CharMinus;
                pend_q.last       <= 1'b0;
                pend_q.empty_res  <= 1'b0;
                ret_q             <= StRead;
                state_q           <= StPut;
              end else begin
                state_q <= StRead;
              end
            end
          end else begin
            rem_q  <= rem_d;
            step_q <= step_q + 1'b1;
          end
        end
        StRead: begin
          state_q <= StChar;
        end
        StChar: begin
          pend_q.digit_char <= digit_to_char(rd_q);
          pend_q.last       <= (cnt_q == CntW'(1));
          pend_q.empty_res  <= 1'b0;
          cnt_q             <= cnt_dec;
          ret_q             <= (cnt_q == CntW'(1)) ? StIdle : StRead;
          state_q           <= StPut;
        end
        StPut: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
            state_q     <= ret_q;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== design/radix_integer_to_ascii_core.sv =====
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_core
// Converts an integer to lower-case ASCII digits in radix 2 to 36, most
// significant first, with a leading minus sign for negative base-10 values.
// ----------------------------------------------------------------------------
// Each item yields one character per digit (plus '-' for a negative signed
// base-10 value); an invalid radix yields a single item flagged empty_res.
// Digits come from a shared restoring divider that retires 4 quotient bits
// per cycle, and characters then leave through a single-port digit stack:
// each is read, mapped to its ASCII code and put in the output register.
// A two-entry queue lets new items be accepted while a conversion is in
// progress.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_core
  import ritoa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CtrlW = $bits(job_ctrl_t);
  localparam int unsigned JobW  = CtrlW + VALUE_WIDTH;

  job_ctrl_t              front_ctrl;
  logic [VALUE_WIDTH-1:0] front_mag;
  logic                   q_full;
  logic                   q_valid;
  logic [JobW-1:0]        q_data;
  logic                   q_pop;
  job_ctrl_t              back_ctrl;
  logic [VALUE_WIDTH-1:0] back_mag;

  ritoa_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .item_i    (in_item_i),
    .job_ctrl_o(front_ctrl),
    .job_mag_o (front_mag)
  );

  ritoa_fifo #(
    .DATA_W(JobW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .data_i ({front_ctrl, front_mag}),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_data),
    .pop_i  (q_pop)
  );

  assign in_stall_o = q_full;
  assign back_ctrl  = q_data[JobW-1 -: CtrlW];
  assign back_mag   = q_data[VALUE_WIDTH-1:0];

  ritoa_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_ctrl_i (back_ctrl),
    .job_mag_i  (back_mag),
    .job_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== design/ritoa_checker.sv =====
// ----------------------------------------------------------------------------
// ritoa_checker
// Port-level checks of the converter's result stream, bound to the core.
// ----------------------------------------------------------------------------
module ritoa_checker
  import ritoa_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");

  a_empty_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.empty_res |-> out_item_o.last && out_item_o.digit_char == '0)
    else $error("empty result not a lone final item");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.empty_res |->
      (out_item_o.digit_char >= CharZero && out_item_o.digit_char <= CharNine) ||
      (out_item_o.digit_char >= CharLowA && out_item_o.digit_char <= CharLowZ) ||
      (out_item_o.digit_char == CharMinus))
    else $error("illegal character");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.empty_res && out_item_o.digit_char == CharMinus
      |-> !out_item_o.last)
    else $error("sign emitted without digits");

endmodule

bind radix_integer_to_ascii_core ritoa_checker u_ritoa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
